FILE: rtl/core/wcs_pkg.sv
`default_nettype none
package wcs_pkg;

	// Field and register widths.
	localparam int PIX_W = 8;
	localparam int CFG_W = 13;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int MODE_W = 2;
	localparam int COL_CMP_W = 14;
	localparam int ROW_W = 12;
	localparam int SQ_W = 22;
	localparam int ROOT_W = 11;
	localparam int WIN_N = 9;

	// Defaults and limits.
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int ROW_LIMIT = 4096;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd1024;

	// Reciprocal of nine in 16 fractional bits; exact floor for sums up to 2295.
	localparam logic [12:0] RECIP9 = 13'd7282;

	// Register indexes.
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	// Filter modes.
	localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HORZ = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MAG = 2'd3;

	// Input opcodes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Sobel coefficients already flipped in both axes, indexed by window
	// position row*3+col.
	localparam logic signed [2:0] SOBEL_V [WIN_N] = '{
		-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1};
	localparam logic signed [2:0] SOBEL_H [WIN_N] = '{
		3'sd1, 3'sd2, 3'sd1, 3'sd0, 3'sd0, 3'sd0, -3'sd1, -3'sd2, -3'sd1};

	typedef struct packed {
		logic opcode;
		logic [PIX_W-1:0] pixel_in;
	} pix_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic frame_last;
	} res_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/wcs_cell.sv
`default_nettype none
module wcs_cell
	import wcs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic shift_en,
	input wire logic [PIX_W-1:0] pix_prev,
	output logic [PIX_W-1:0] pix
);

	logic [PIX_W-1:0] pix_q;

	// Take the neighbor's pixel on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift_en) begin
			pix_q <= pix_prev;
		end
	end

	assign pix = pix_q;

endmodule
`default_nettype wire

FILE: rtl/core/wcs_isqrt.sv
`default_nettype none
module wcs_isqrt
	import wcs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SQ_W-1:0] value,
	output logic done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic busy_q;
	logic done_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	// One result bit per cycle, starting at the top power of four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/window_conv_sobel_mean_3x3_top.sv
// Sequence: a word that completes a window passes check, nine reads of the row memory,
// settle, convolve, square and finish; in magnitude mode finish also waits for the
// bit-serial square root, and finish waits while the last result is not yet taken.
// A word that completes none goes from check back to idle. Throughput: one word at a time.
// Reset: arst_n clears the counters, the window and the registers to their defaults;
// the row memory is not cleared, and only pixels of the current frame are read.
`default_nettype none
module window_conv_sobel_mean_3x3_top
	import wcs_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	output logic pix_ready,
	input wire pix_word_t pix_data,
	output logic res_valid,
	input wire logic res_ready,
	output res_word_t res_data,
	input wire logic cfg_wen,
	input wire logic [1:0] cfg_idx,
	input wire logic [CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DEPTH = 4 << AW;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_READ = 7'b0000100,
		ST_SETTLE = 7'b0001000,
		ST_CONV = 7'b0010000,
		ST_SQ = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;

	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [MODE_W-1:0] mode_q;

	logic [AW-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic input_done_q;
	logic [AW-1:0] em_col_q;
	logic [ROW_W-1:0] em_row_q;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;
	logic rd_en_s1;
	logic [1:0] kr_q;
	logic [1:0] kc_q;

	logic signed [11:0] v_q;
	logic signed [11:0] h_q;
	logic [11:0] sum_q;
	logic [PIX_W-1:0] mean_q;

	logic res_valid_q;
	res_word_t res_q;

	// Effective frame size.
	logic [COL_CMP_W-1:0] w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;

	always_comb begin
		w_eff = COL_CMP_W'(width_q);
		if (width_q == '0) begin
			w_eff = COL_CMP_W'(1);
		end else if (COL_CMP_W'(width_q) > COL_CMP_W'(MAX_WIDTH)) begin
			w_eff = COL_CMP_W'(MAX_WIDTH);
		end
		h_eff = height_q;
		if (height_q == '0) begin
			h_eff = HEIGHT_REG_W'(1);
		end else if (height_q > HEIGHT_REG_W'(ROW_LIMIT)) begin
			h_eff = HEIGHT_REG_W'(ROW_LIMIT);
		end
	end

	logic accept;
	logic store_px;
	logic in_col_end;
	logic in_row_end;
	logic em_col_end;
	logic em_row_end;

	assign pix_ready = (state_q == ST_IDLE);
	assign accept = pix_valid && pix_ready;
	assign store_px = accept && (pix_data.opcode == OP_PIXEL) && !input_done_q;
	assign in_col_end = (COL_CMP_W'(in_col_q) + COL_CMP_W'(1) >= w_eff);
	assign in_row_end = (HEIGHT_REG_W'(in_row_q) + HEIGHT_REG_W'(1) >= h_eff);
	assign em_col_end = (COL_CMP_W'(em_col_q) + COL_CMP_W'(1) >= w_eff);
	assign em_row_end = (HEIGHT_REG_W'(em_row_q) + HEIGHT_REG_W'(1) >= h_eff);

	// Last pixel needed by the next output position, and whether it is in.
	logic [ROW_W-1:0] need_row;
	logic [AW-1:0] need_col;
	logic win_ready;

	always_comb begin
		need_row = em_row_end ? em_row_q : em_row_q + ROW_W'(1);
		need_col = em_col_end ? em_col_q : em_col_q + AW'(1);
		win_ready = input_done_q || (need_row < in_row_q) ||
			((need_row == in_row_q) && (need_col < in_col_q));
	end

	// Window tap address with edge replication.
	logic [ROW_W-1:0] tap_row;
	logic [AW-1:0] tap_col;

	always_comb begin
		tap_row = em_row_q;
		if (kr_q == 2'd0 && em_row_q != '0) begin
			tap_row = em_row_q - ROW_W'(1);
		end else if (kr_q == 2'd2 && !em_row_end) begin
			tap_row = em_row_q + ROW_W'(1);
		end
		tap_col = em_col_q;
		if (kc_q == 2'd0 && em_col_q != '0) begin
			tap_col = em_col_q - AW'(1);
		end else if (kc_q == 2'd2 && !em_col_end) begin
			tap_col = em_col_q + AW'(1);
		end
	end

	// Row memory: four rows in rotation, one write and one read port.
	always_ff @(posedge clk) begin
		if (store_px) begin
			mem[{in_row_q[1:0], in_col_q}] <= pix_data.pixel_in;
		end
		if (state_q == ST_READ) begin
			rd_data_q <= mem[{tap_row[1:0], tap_col}];
		end
	end

	// Window chain: read data enters cell 0 and moves one cell per read.
	logic [PIX_W-1:0] cell_pix [WIN_N];

	genvar g;
	generate
		for (g = 0; g < WIN_N; g++) begin : g_cell
			wcs_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift_en(rd_en_s1),
				.pix_prev((g == 0) ? rd_data_q : cell_pix[(g == 0) ? 0 : g - 1]),
				.pix(cell_pix[g])
			);
		end
	endgenerate

	// Convolution sums over the window; position k sits in cell 8-k.
	logic signed [11:0] v_acc;
	logic signed [11:0] h_acc;
	logic [11:0] sum_acc;

	always_comb begin
		v_acc = '0;
		h_acc = '0;
		sum_acc = '0;
		for (int k = 0; k < WIN_N; k++) begin
			v_acc = v_acc + 12'(SOBEL_V[k]) * $signed({4'd0, cell_pix[WIN_N-1-k]});
			h_acc = h_acc + 12'(SOBEL_H[k]) * $signed({4'd0, cell_pix[WIN_N-1-k]});
			sum_acc = sum_acc + 12'(cell_pix[WIN_N-1-k]);
		end
	end

	// Square root for the magnitude mode, fed from the registered Sobel sums.
	logic sqrt_start;
	logic sqrt_done;
	logic sqrt_ok;
	logic [ROOT_W-1:0] root;
	logic [23:0] v_sq;
	logic [23:0] h_sq;
	logic [SQ_W-1:0] sq_sum;

	assign v_sq = 24'(v_q) * 24'(v_q);
	assign h_sq = 24'(h_q) * 24'(h_q);
	assign sq_sum = SQ_W'(v_sq) + SQ_W'(h_sq);
	assign sqrt_start = (state_q == ST_SQ) && (mode_q == MODE_MAG);

	wcs_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.value(sq_sum),
		.done(sqrt_done),
		.root(root)
	);

	// Final value per mode.
	logic [PIX_W-1:0] value;

	always_comb begin
		case (mode_q)
			MODE_MEAN: value = mean_q;
			MODE_VERT: value = v_q[11] ? '0 : ((v_q > 12'sd255) ? 8'd255 : v_q[7:0]);
			MODE_HORZ: value = h_q[11] ? '0 : ((h_q > 12'sd255) ? 8'd255 : h_q[7:0]);
			default: value = (root > ROOT_W'(255)) ? 8'd255 : root[7:0];
		endcase
	end

	logic out_free;
	logic frame_end;
	logic fin_fire;

	assign out_free = !res_valid_q || res_ready;
	assign frame_end = em_row_end && em_col_end;
	assign fin_fire = (state_q == ST_FINISH) &&
		(mode_q != MODE_MAG || sqrt_done || sqrt_ok) && out_free;

	// Sequencer and frame counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q <= MODE_VERT;
			in_col_q <= '0;
			in_row_q <= '0;
			input_done_q <= 1'b0;
			em_col_q <= '0;
			em_row_q <= '0;
			kr_q <= '0;
			kc_q <= '0;
			rd_en_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_en_s1 <= (state_q == ST_READ);
			res_valid_q <= fin_fire || (res_valid_q && !res_ready);
			if (cfg_wen) begin
				case (cfg_idx)
					REG_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
					REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
					default: ;
				endcase
				if (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT) begin
					in_col_q <= '0;
					in_row_q <= '0;
					input_done_q <= 1'b0;
					em_col_q <= '0;
					em_row_q <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
					if (store_px) begin
						if (in_col_end) begin
							in_col_q <= '0;
							if (in_row_end) begin
								in_row_q <= '0;
								input_done_q <= 1'b1;
							end else begin
								in_row_q <= in_row_q + ROW_W'(1);
							end
						end else begin
							in_col_q <= in_col_q + AW'(1);
						end
					end
				end
				ST_CHECK: begin
					kr_q <= '0;
					kc_q <= '0;
					state_q <= win_ready ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					if (kc_q == 2'd2) begin
						kc_q <= '0;
						kr_q <= kr_q + 2'd1;
						if (kr_q == 2'd2) begin
							state_q <= ST_SETTLE;
						end
					end else begin
						kc_q <= kc_q + 2'd1;
					end
				end
				ST_SETTLE: state_q <= ST_CONV;
				ST_CONV: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
						if (frame_end) begin
							in_col_q <= '0;
							in_row_q <= '0;
							input_done_q <= 1'b0;
							em_col_q <= '0;
							em_row_q <= '0;
						end else if (em_col_end) begin
							em_col_q <= '0;
							em_row_q <= em_row_q + ROW_W'(1);
						end else begin
							em_col_q <= em_col_q + AW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Arithmetic stages and result word.
	logic [24:0] mean_prod;

	assign mean_prod = 25'(sum_q) * 25'(RECIP9);

	// Magnitude result stays pending once the root is in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_ok <= 1'b0;
		end else if (sqrt_start) begin
			sqrt_ok <= 1'b0;
		end else if (sqrt_done) begin
			sqrt_ok <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CONV) begin
			v_q <= v_acc;
			h_q <= h_acc;
			sum_q <= sum_acc;
		end
		if (state_q == ST_SQ) begin
			mean_q <= mean_prod[23:16];
		end
		if (state_q == ST_FINISH && out_free) begin
			res_q.pixel_out <= value;
			res_q.frame_last <= frame_end;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

endmodule
`default_nettype wire
